// ----- hdl/irc2h_pkg.sv -----
// Shared types, token codes and control byte codes for the chat-format token converter.
package irc2h_pkg;

  // Token kinds on the result channel.
  typedef logic [2:0] tok_kind_t;
  localparam tok_kind_t TK_LIT        = 3'd0;
  localparam tok_kind_t TK_BOLD_ON    = 3'd1;
  localparam tok_kind_t TK_BOLD_OFF   = 3'd2;
  localparam tok_kind_t TK_UL_ON      = 3'd3;
  localparam tok_kind_t TK_UL_OFF     = 3'd4;
  localparam tok_kind_t TK_FONT_OPEN  = 3'd5;
  localparam tok_kind_t TK_FONT_CLOSE = 3'd6;
  localparam tok_kind_t TK_END        = 3'd7;

  // Control bytes in the text stream.
  localparam logic [7:0] CH_END       = 8'h00;
  localparam logic [7:0] CH_BOLD      = 8'h02;
  localparam logic [7:0] CH_COLOR     = 8'h03;
  localparam logic [7:0] CH_BELL      = 8'h07;
  localparam logic [7:0] CH_RESET     = 8'h0F;
  localparam logic [7:0] CH_REVERSE   = 8'h16;
  localparam logic [7:0] CH_UNDERLINE = 8'h1F;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_DIGIT0    = 8'h30;
  localparam logic [7:0] CH_DIGIT9    = 8'h39;

  // Largest color index that opens a font.
  localparam logic [6:0] COLOR_MAX = 7'd15;

  // Token slots of one record, in the order they leave the block.
  localparam int NSLOT        = 7;
  localparam int SLOT_FC1     = 0;  // font close that finishes a color code
  localparam int SLOT_FO      = 1;  // font open that finishes a color code
  localparam int SLOT_ONE     = 2;  // literal, bold toggle or underline toggle
  localparam int SLOT_BOLDOFF = 3;  // close-all: bold off
  localparam int SLOT_ULOFF   = 4;  // close-all: underline off
  localparam int SLOT_FC2     = 5;  // close-all: font close
  localparam int SLOT_END     = 6;  // end of string

  typedef logic [NSLOT-1:0] slot_mask_t;

  // Everything one input byte causes, in compact form.
  typedef struct packed {
    slot_mask_t slots;
    tok_kind_t  one_kind;
    logic [7:0] text_byte;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       has_bg;
  } tok_rec_t;

  // Record queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Parse phases of the front end.
  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_FG1   = 3'd2;
  localparam logic [2:0] PH_FG2   = 3'd3;
  localparam logic [2:0] PH_COMMA = 3'd4;
  localparam logic [2:0] PH_BG1   = 3'd5;

endpackage

// ----- hdl/irc2h_front.sv -----
// Front end: parses each text byte and turns it into one token record.
module irc2h_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        ch,
  output logic              push,
  output irc2h_pkg::tok_rec_t rec
);
  import irc2h_pkg::*;

  logic [2:0] phase_r, phase_nxt;
  logic [6:0] fg_value_r, fg_value_nxt;
  logic       fg_present_r, fg_present_nxt;
  logic [6:0] bg_value_r, bg_value_nxt;
  logic       bold_r, bold_nxt;
  logic       ul_r, ul_nxt;
  logic       font_r, font_nxt;

  logic       is_digit;
  logic [3:0] dval;
  logic [6:0] fg_acc;
  logic [6:0] bg_acc;
  logic       finish;
  logic       with_bg;
  logic       plain;
  logic       font_mid;
  logic       bg_ok;

  assign is_digit = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT9);
  assign dval     = ch[3:0];
  // value * 10 + digit, kept to seven bits
  assign fg_acc   = 7'({fg_value_r, 3'b000} + {fg_value_r, 1'b0} + {3'b000, dval});
  assign bg_acc   = 7'({bg_value_r, 3'b000} + {bg_value_r, 1'b0} + {3'b000, dval});

  always_comb begin
    phase_nxt      = phase_r;
    fg_value_nxt   = fg_value_r;
    fg_present_nxt = fg_present_r;
    bg_value_nxt   = bg_value_r;
    bold_nxt       = bold_r;
    ul_nxt         = ul_r;
    finish         = 1'b0;
    with_bg        = 1'b0;
    plain          = 1'b0;
    font_mid       = font_r;
    bg_ok          = 1'b0;
    rec            = '0;

    unique case (phase_r)
      PH_START, PH_FG1: begin
        if (is_digit) begin
          fg_value_nxt   = fg_acc;
          fg_present_nxt = 1'b1;
          phase_nxt      = phase_r + 3'd1;
        end else if (ch == CH_COMMA) begin
          phase_nxt = PH_COMMA;
        end else begin
          finish = 1'b1;
          plain  = 1'b1;
        end
      end
      PH_FG2: begin
        if (ch == CH_COMMA) begin
          phase_nxt = PH_COMMA;
        end else begin
          finish = 1'b1;
          plain  = 1'b1;
        end
      end
      PH_COMMA: begin
        if (is_digit) begin
          bg_value_nxt = {3'b000, dval};
          phase_nxt    = PH_BG1;
        end else begin
          finish = 1'b1;
          plain  = 1'b1;
        end
      end
      PH_BG1: begin
        finish  = 1'b1;
        with_bg = 1'b1;
        if (is_digit) begin
          bg_value_nxt = bg_acc;
        end else begin
          plain = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_PLAIN;
        plain     = 1'b1;
      end
    endcase

    // The color code ends: close an open font, then open the new one if valid.
    if (finish) begin
      phase_nxt = PH_PLAIN;
      if (font_r) begin
        rec.slots[SLOT_FC1] = 1'b1;
        font_mid            = 1'b0;
      end
      if (fg_present_r && (fg_value_r <= COLOR_MAX)) begin
        bg_ok               = with_bg && (bg_value_nxt <= COLOR_MAX);
        rec.slots[SLOT_FO]  = 1'b1;
        rec.fg_color        = fg_value_r[3:0];
        rec.has_bg          = bg_ok;
        rec.bg_color        = bg_ok ? bg_value_nxt[3:0] : 4'd0;
        font_mid            = 1'b1;
      end
    end

    font_nxt = font_mid;

    if (plain) begin
      unique case (ch)
        CH_BOLD: begin
          rec.slots[SLOT_ONE] = 1'b1;
          rec.one_kind        = bold_r ? TK_BOLD_OFF : TK_BOLD_ON;
          bold_nxt            = !bold_r;
        end
        CH_UNDERLINE: begin
          rec.slots[SLOT_ONE] = 1'b1;
          rec.one_kind        = ul_r ? TK_UL_OFF : TK_UL_ON;
          ul_nxt              = !ul_r;
        end
        CH_BELL, CH_REVERSE: begin
        end
        CH_COLOR: begin
          phase_nxt      = PH_START;
          fg_value_nxt   = '0;
          fg_present_nxt = 1'b0;
          bg_value_nxt   = '0;
        end
        CH_RESET, CH_END: begin
          rec.slots[SLOT_BOLDOFF] = bold_r;
          rec.slots[SLOT_ULOFF]   = ul_r;
          rec.slots[SLOT_FC2]     = font_mid;
          bold_nxt                = 1'b0;
          ul_nxt                  = 1'b0;
          font_nxt                = 1'b0;
          if (ch == CH_END) begin
            rec.slots[SLOT_END] = 1'b1;
            phase_nxt           = PH_PLAIN;
            fg_value_nxt        = '0;
            fg_present_nxt      = 1'b0;
            bg_value_nxt        = '0;
          end
        end
        default: begin
          rec.slots[SLOT_ONE] = 1'b1;
          rec.one_kind        = TK_LIT;
          rec.text_byte       = ch;
        end
      endcase
    end
  end

  assign push = accept && (rec.slots != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PLAIN;
      fg_value_r   <= '0;
      fg_present_r <= 1'b0;
      bg_value_r   <= '0;
      bold_r       <= 1'b0;
      ul_r         <= 1'b0;
      font_r       <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      fg_value_r   <= fg_value_nxt;
      fg_present_r <= fg_present_nxt;
      bg_value_r   <= bg_value_nxt;
      bold_r       <= bold_nxt;
      ul_r         <= ul_nxt;
      font_r       <= font_nxt;
    end
  end

endmodule

// ----- hdl/irc2h_queue.sv -----
// Short record queue that decouples the parser from the token emitter.
module irc2h_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  irc2h_pkg::tok_rec_t push_rec,
  input  logic                pop,
  output logic                not_full,
  output logic                not_empty,
  output irc2h_pkg::tok_rec_t head_rec
);
  import irc2h_pkg::*;

  tok_rec_t       mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign not_full   = (count_r != (QAW+1)'(QDEPTH));
  assign not_empty  = (count_r != '0);
  assign head_rec   = mem[rd_ptr_r];
  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/irc2h_back.sv -----
// Back end: expands the record at the queue head into tokens, one per cycle while out_ready allows.
module irc2h_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  irc2h_pkg::tok_rec_t   head_rec,
  output logic                  pop,
  input  logic                  out_ready,
  output logic                  out_valid,
  output irc2h_pkg::tok_kind_t  out_token_kind,
  output logic [7:0]            out_text_byte,
  output logic [3:0]            out_fg_color,
  output logic [3:0]            out_bg_color,
  output logic                  out_has_bg,
  output logic                  out_last_of_run
);
  import irc2h_pkg::*;

  slot_mask_t done_r, done_nxt;
  logic       valid_r, valid_nxt;
  tok_kind_t  kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [3:0] fg_r, fg_nxt;
  logic [3:0] bg_r, bg_nxt;
  logic       hb_r, hb_nxt;
  logic       last_r, last_nxt;

  slot_mask_t rem;
  slot_mask_t sel;
  slot_mask_t rest;
  logic       emit;

  assign rem  = head_rec.slots & ~done_r;
  assign sel  = rem & (~rem + 1'b1);
  assign rest = rem & ~sel;
  assign emit = head_valid && (!valid_r || out_ready);
  assign pop  = emit && (rest == '0);

  always_comb begin
    kind_nxt = TK_END;
    byte_nxt = '0;
    fg_nxt   = '0;
    bg_nxt   = '0;
    hb_nxt   = 1'b0;
    priority if (rem[SLOT_FC1]) begin
      kind_nxt = TK_FONT_CLOSE;
    end else if (rem[SLOT_FO]) begin
      kind_nxt = TK_FONT_OPEN;
      fg_nxt   = head_rec.fg_color;
      bg_nxt   = head_rec.bg_color;
      hb_nxt   = head_rec.has_bg;
    end else if (rem[SLOT_ONE]) begin
      kind_nxt = head_rec.one_kind;
      byte_nxt = head_rec.text_byte;
    end else if (rem[SLOT_BOLDOFF]) begin
      kind_nxt = TK_BOLD_OFF;
    end else if (rem[SLOT_ULOFF]) begin
      kind_nxt = TK_UL_OFF;
    end else if (rem[SLOT_FC2]) begin
      kind_nxt = TK_FONT_CLOSE;
    end else begin
      kind_nxt = TK_END;
    end
    last_nxt = (rest == '0);
  end

  always_comb begin
    done_nxt  = done_r;
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
      done_nxt  = pop ? '0 : (done_r | sel);
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      fg_r   <= fg_nxt;
      bg_r   <= bg_nxt;
      hb_r   <= hb_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_token_kind  = kind_r;
  assign out_text_byte   = byte_r;
  assign out_fg_color    = fg_r;
  assign out_bg_color    = bg_r;
  assign out_has_bg      = hb_r;
  assign out_last_of_run = last_r;

endmodule

// ----- hdl/irc_format_code_to_html_tokens_unit.sv -----
// Top level of the chat-format to markup token converter.
//
// Text bytes enter on the in_ channel, one per transaction, and a zero byte
// ends a string. Each byte yields zero to six tokens on the out_ channel;
// out_last_of_run marks the last token of a byte, so a byte that yields no
// token (a foreground digit, a comma inside a color code, or a dropped control
// byte) leaves no trace on the output. A byte is taken in the cycle it is
// offered as long as the four-entry record queue between the parser and the
// token emitter has room; the parser finishes its work on a byte in that same
// cycle. The emitter sends one token per cycle while out_ready is high, so
// the sustained rate is one byte per cycle for text that yields one token per
// byte, and a byte with more than one token holds the emitter until its last
// token is sent, while the queue absorbs the burst. The first token of a byte
// passes through the record queue, then the output register. Reset clears the
// parse state, the open-tag flags and the queue; no configuration is needed.

module irc_format_code_to_html_tokens_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_ch,
  output logic                  out_valid,
  input  logic                  out_ready,
  output irc2h_pkg::tok_kind_t  out_token_kind,
  output logic [7:0]            out_text_byte,
  output logic [3:0]            out_fg_color,
  output logic [3:0]            out_bg_color,
  output logic                  out_has_bg,
  output logic                  out_last_of_run
);
  import irc2h_pkg::*;

  logic     accept;
  logic     push;
  tok_rec_t push_rec;
  logic     pop;
  logic     q_not_full;
  logic     q_not_empty;
  tok_rec_t head_rec;

  // The parser never stalls on its own: a byte is refused only when the
  // queue could not take the record it may produce.
  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;

  irc2h_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .ch     (in_ch),
    .push   (push),
    .rec    (push_rec)
  );

  irc2h_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  // The emitter walks the head record's token slots in order and releases
  // the record together with its last token, so there is no bubble between
  // records.
  irc2h_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_not_empty),
    .head_rec        (head_rec),
    .pop             (pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_token_kind  (out_token_kind),
    .out_text_byte   (out_text_byte),
    .out_fg_color    (out_fg_color),
    .out_bg_color    (out_bg_color),
    .out_has_bg      (out_has_bg),
    .out_last_of_run (out_last_of_run)
  );

endmodule
